// ===== rtl/chm_pkg.sv =====
// Shared constants, codes, types and helper functions for the hash map engine.
`default_nettype none

package chm_pkg;

  localparam int NODE_COUNT   = 256;
  localparam int BUCKET_COUNT = 512;
  localparam int NODE_AW      = $clog2(NODE_COUNT);
  localparam int LINK_W       = $clog2(NODE_COUNT + 1);
  localparam int BKT_AW       = $clog2(BUCKET_COUNT);

  localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
  // The prime is 2^40 + 0x1B3, so one multiply is a shift plus a narrow product.
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
  localparam int          FNV_SHIFT    = 40;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_EXISTS    = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  typedef struct packed {
    logic       load;
    logic       hash_step;
    logic       head_rd;
    logic       head_take;
    logic       node_rd;
    logic       advance;
    logic       alloc;
    logic       pop;
    logic       ins;
    logic       upd;
    logic       unlink;
    logic       push;
    logic       out_load;
    logic [2:0] code;
  } chm_cmd_t;

  typedef struct packed {
    logic       clr_busy;
    logic       hash_done;
    logic       link_zero;
    logic       match;
    logic       full;
    logic       free_empty;
    logic       out_free;
    logic [1:0] kind;
  } chm_sts_t;

  typedef struct packed {
    logic [63:0] hash;
    logic [63:0] key;
    logic [3:0]  klen;
  } chm_key_ent_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] p;
    p = h ^ {56'd0, b};
    return (p << FNV_SHIFT) + (p * {55'd0, FNV_PRIME_LO});
  endfunction

endpackage

`default_nettype wire

// ===== rtl/chm_ctrl.sv =====
// Sequencing state machine for the hash map engine.
`default_nettype none

module chm_ctrl import chm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire chm_sts_t sts,
  output chm_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HASH   = 4'd1;
  localparam logic [3:0] S_HEADW  = 4'd2;
  localparam logic [3:0] S_WALK   = 4'd3;
  localparam logic [3:0] S_CMP    = 4'd4;
  localparam logic [3:0] S_ALLOC  = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_INS    = 4'd7;
  localparam logic [3:0] S_UPD    = 4'd8;
  localparam logic [3:0] S_UNLINK = 4'd9;
  localparam logic [3:0] S_PUSH   = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [2:0] code_r, code_nxt;

  assign in_stall = !((state_r == S_IDLE) && !sts.clr_busy);

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.code  = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.hash_done) begin
          cmd.head_rd = 1'b1;
          state_nxt   = S_HEADW;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_HEADW: begin
        cmd.head_take = 1'b1;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        if (sts.link_zero) begin
          if (sts.kind == KIND_ADD || sts.kind == KIND_UPDATE) begin
            if (sts.full) begin
              code_nxt  = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_ALLOC;
            end
          end else begin
            code_nxt  = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          unique case (sts.kind)
            KIND_ADD: begin
              code_nxt  = ST_EXISTS;
              state_nxt = S_DONE;
            end
            KIND_UPDATE: state_nxt = S_UPD;
            KIND_LOOKUP: begin
              code_nxt  = ST_FOUND;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_UNLINK;
          endcase
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_WALK;
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = sts.free_empty ? S_INS : S_POP;
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_INS;
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        code_nxt  = ST_ADDED;
        state_nxt = S_DONE;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        code_nxt  = ST_UPDATED;
        state_nxt = S_DONE;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = S_PUSH;
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        code_nxt  = ST_REMOVED;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_ADDED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/chm_dp.sv =====
// Datapath: hash unit, bucket and node memories, allocator and result register.
`default_nettype none

module chm_dp import chm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  in_kind,
  input  wire logic [63:0] in_key,
  input  wire logic [3:0]  in_key_length,
  input  wire logic [63:0] in_value,
  input  wire logic [3:0]  in_value_length,
  input  wire logic        in_has_value,
  input  wire chm_cmd_t    cmd,
  output chm_sts_t         sts,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [63:0]      out_found_value,
  output logic [3:0]       out_found_value_length,
  output logic             out_found_has_value,
  output logic [LINK_W-1:0] out_entry_total
);

  logic [1:0]        kind_r;
  logic [63:0]       key_r;
  logic [3:0]        klen_r;
  logic [63:0]       val_r;
  logic [4:0]        vmeta_r;
  logic [63:0]       h_r;
  logic [3:0]        idx_r;
  logic [LINK_W-1:0] head_r, link_r, prev_r, alloc_r;
  logic [LINK_W-1:0] free_top_r, hw_r, cnt_r;
  logic              clr_busy_r;
  logic [BKT_AW-1:0] clr_cnt_r;
  logic              out_valid_r;

  logic [LINK_W-1:0] bkt_mem [BUCKET_COUNT];
  chm_key_ent_t      key_mem [NODE_COUNT];
  logic [68:0]       val_mem [NODE_COUNT];
  logic [LINK_W-1:0] nxt_mem [NODE_COUNT];

  logic [LINK_W-1:0] head_q, nxt_q;
  chm_key_ent_t      key_q;
  logic [68:0]       val_q;

  logic [3:0]        klen_in, vlen_in;
  logic [BKT_AW-1:0] bucket;
  logic [LINK_W-1:0] link_m1, prev_m1, alloc_m1, free_m1, cnt_dec;
  logic [NODE_AW-1:0] nrd_addr, nwr_addr, vwr_addr;
  logic              prev_zero, bkt_we, nxt_we;
  logic [BKT_AW-1:0] bkt_addr;
  logic [LINK_W-1:0] bkt_wdata, nxt_wdata;
  logic              show_found;

  assign klen_in   = (in_key_length > 4'd8) ? 4'd8 : in_key_length;
  assign vlen_in   = (in_value_length > 4'd8) ? 4'd8 : in_value_length;
  assign bucket    = h_r[BKT_AW-1:0];
  assign link_m1   = link_r - 1'b1;
  assign prev_m1   = prev_r - 1'b1;
  assign alloc_m1  = alloc_r - 1'b1;
  assign free_m1   = free_top_r - 1'b1;
  assign cnt_dec   = cnt_r - 1'b1;
  assign prev_zero = (prev_r == '0);

  assign nrd_addr = cmd.alloc ? free_m1[NODE_AW-1:0] : link_m1[NODE_AW-1:0];
  assign vwr_addr = cmd.ins ? alloc_m1[NODE_AW-1:0] : link_m1[NODE_AW-1:0];

  always_comb begin
    bkt_we    = clr_busy_r || cmd.ins || (cmd.unlink && prev_zero);
    bkt_addr  = clr_busy_r ? clr_cnt_r : bucket;
    bkt_wdata = clr_busy_r ? '0 : (cmd.ins ? alloc_r : nxt_q);
    nxt_we    = cmd.ins || cmd.push || (cmd.unlink && !prev_zero);
    if (cmd.ins) begin
      nwr_addr  = alloc_m1[NODE_AW-1:0];
      nxt_wdata = head_r;
    end else if (cmd.push) begin
      nwr_addr  = link_m1[NODE_AW-1:0];
      nxt_wdata = free_top_r;
    end else begin
      nwr_addr  = prev_m1[NODE_AW-1:0];
      nxt_wdata = nxt_q;
    end
  end

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_addr] <= bkt_wdata;
    if (cmd.head_rd) head_q <= bkt_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) key_mem[alloc_m1[NODE_AW-1:0]] <= '{hash: h_r, key: key_r, klen: klen_r};
    if (cmd.node_rd) key_q <= key_mem[nrd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins || cmd.upd) val_mem[vwr_addr] <= {vmeta_r, val_r};
    if (cmd.node_rd) val_q <= val_mem[nrd_addr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nwr_addr] <= nxt_wdata;
    if (cmd.node_rd || cmd.alloc) nxt_q <= nxt_mem[nrd_addr];
  end

  // Request and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      key_r   <= in_key & byte_mask(klen_in);
      klen_r  <= klen_in;
      val_r   <= in_has_value ? (in_value & byte_mask(vlen_in)) : 64'd0;
      vmeta_r <= in_has_value ? {1'b1, vlen_in} : 5'd0;
      h_r     <= FNV_BASIS;
      idx_r   <= 4'd0;
    end else if (cmd.hash_step) begin
      h_r   <= fnv_step(h_r, key_r[{idx_r[2:0], 3'b000} +: 8]);
      idx_r <= idx_r + 4'd1;
    end
    if (cmd.head_take) begin
      head_r <= head_q;
      link_r <= head_q;
      prev_r <= '0;
    end else if (cmd.advance) begin
      prev_r <= link_r;
      link_r <= nxt_q;
    end
    if (cmd.alloc && free_top_r == '0) alloc_r <= hw_r + 1'b1;
    else if (cmd.pop) alloc_r <= free_top_r;
  end

  // Allocator and entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_top_r <= '0;
      hw_r       <= '0;
      cnt_r      <= '0;
    end else begin
      if (cmd.alloc && free_top_r == '0) hw_r <= hw_r + 1'b1;
      if (cmd.pop) free_top_r <= nxt_q;
      if (cmd.ins) cnt_r <= cnt_r + 1'b1;
      if (cmd.push) begin
        cnt_r <= cnt_dec;
        if (cnt_dec == '0) begin
          free_top_r <= '0;
          hw_r       <= '0;
        end else begin
          free_top_r <= link_r;
        end
      end
    end
  end

  // Bucket clearing pass after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == BKT_AW'(BUCKET_COUNT - 1)) clr_busy_r <= 1'b0;
    end
  end

  // Result register.
  assign show_found = (cmd.code == ST_FOUND) || (cmd.code == ST_REMOVED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status             <= cmd.code;
      out_found_value        <= show_found ? val_q[63:0] : 64'd0;
      out_found_value_length <= show_found ? val_q[67:64] : 4'd0;
      out_found_has_value    <= show_found ? val_q[68] : 1'b0;
      out_entry_total        <= cnt_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.clr_busy   = clr_busy_r;
    sts.hash_done  = (idx_r >= klen_r);
    sts.link_zero  = (link_r == '0);
    sts.match      = (key_q.hash == h_r) && (key_q.klen == klen_r) && (key_q.key == key_r);
    sts.full       = (cnt_r == LINK_W'(NODE_COUNT));
    sts.free_empty = (free_top_r == '0);
    sts.out_free   = !out_valid_r || !out_stall;
    sts.kind       = kind_r;
  end

endmodule

`default_nettype wire

// ===== rtl/chained_hash_map_engine_core.sv =====
// Top level of the chained hash map engine: controller plus datapath.
//
//   Channel | Direction | Handshake           | Word
//   in_     | input     | in_valid / in_stall   | kind, key, lengths, value
//   out_    | output    | out_valid / out_stall | status, found value, entry total
//
// An operation hashes the key with FNV-1a, one byte per multiply step
// (one multiply step per cycle), then reads each chain node visited
// through the registered port of the node memory before comparing it.
// Inserts add the alloc, optional pop and insert states; removes add unlink and push.
// After reset a clearing pass writes all 512 bucket heads to zero, one per
// cycle; in_stall stays high until the pass ends.
// A finished word waits in the output register; the next input word is
// taken while it waits, and its own result is held back until the register frees.
`default_nettype none

module chained_hash_map_engine_core import chm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [63:0] in_key,
  input  wire logic [3:0]  in_key_length,
  input  wire logic [63:0] in_value,
  input  wire logic [3:0]  in_value_length,
  input  wire logic        in_has_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [63:0]      out_found_value,
  output logic [3:0]       out_found_value_length,
  output logic             out_found_has_value,
  output logic [8:0]       out_entry_total
);

  chm_cmd_t cmd;
  chm_sts_t sts;

  // The controller only sequences; all state of the map lives in the datapath.
  chm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  chm_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_kind                (in_kind),
    .in_key                 (in_key),
    .in_key_length          (in_key_length),
    .in_value               (in_value),
    .in_value_length        (in_value_length),
    .in_has_value           (in_has_value),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_found_value        (out_found_value),
    .out_found_value_length (out_found_value_length),
    .out_found_has_value    (out_found_has_value),
    .out_entry_total        (out_entry_total)
  );

endmodule

`default_nettype wire

// ===== rtl/chm_checker.sv =====
// Port-level checks for the hash map engine, bound to the top level.
`default_nettype none

module chm_checker import chm_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [63:0] out_found_value,
  input wire logic [3:0]  out_found_value_length,
  input wire logic        out_found_has_value,
  input wire logic [8:0]  out_entry_total
);

  // A stalled result word must stay put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_entry_total))
    else $error("stalled result word changed");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_FULL)
    else $error("unknown status code");

  // Only a found or removed entry returns a value.
  a_novalue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FOUND && out_status != ST_REMOVED |->
      out_found_value == 64'd0 && out_found_value_length == 4'd0 && !out_found_has_value)
    else $error("value returned without a hit");

  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_total <= 9'd256 && out_found_value_length <= 4'd8)
    else $error("entry total or value length out of range");

endmodule

bind chained_hash_map_engine_core chm_checker u_chm_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_status             (out_status),
  .out_found_value        (out_found_value),
  .out_found_value_length (out_found_value_length),
  .out_found_has_value    (out_found_has_value),
  .out_entry_total        (out_entry_total)
);

`default_nettype wire

// ===== dv/chm_checker.sv =====
// Result checker for the hash map engine: predicts each result word and compares it.
`timescale 1ns / 1ps
`default_nettype none

module chm_result_check import chm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [63:0] in_key,
  input  wire logic [3:0]  in_key_length,
  input  wire logic [63:0] in_value,
  input  wire logic [3:0]  in_value_length,
  input  wire logic        in_has_value,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  out_status,
  input  wire logic [63:0] out_found_value,
  input  wire logic [3:0]  out_found_value_length,
  input  wire logic        out_found_has_value,
  input  wire logic [8:0]  out_entry_total,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] fval;
    logic [3:0]  flen;
    logic        fhv;
    logic [8:0]  total;
  } map_result_t;

  map_result_t result_queue[$];

  // Shadow copy of the map; links are 1-based, zero ends a chain.
  int unsigned   head_link[BUCKET_COUNT];
  logic [63:0]   shadow_key[NODE_COUNT];
  logic [3:0]    shadow_klen[NODE_COUNT];
  logic [63:0]   shadow_hash[NODE_COUNT];
  logic [63:0]   shadow_val[NODE_COUNT];
  logic [3:0]    shadow_vlen[NODE_COUNT];
  logic          shadow_hv[NODE_COUNT];
  int unsigned   next_link[NODE_COUNT];
  int unsigned   free_link, taken_count, live_count;

  function automatic logic [63:0] mask_bytes(int unsigned n);
    return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  function automatic logic [63:0] fnv_hash(logic [63:0] k, int unsigned n);
    logic [63:0] h;
    h = 64'hCBF29CE484222325;
    for (int i = 0; i < n; i++) h = (h ^ {56'd0, k[8*i +: 8]}) * 64'h00000100000001B3;
    return h;
  endfunction

  task automatic store_value(int unsigned n, logic [63:0] v, int unsigned vl, logic hv);
    shadow_val[n]  = hv ? (v & mask_bytes(vl)) : '0;
    shadow_vlen[n] = hv ? 4'(vl) : 4'd0;
    shadow_hv[n]   = hv;
  endtask

  task automatic apply_operation(logic [1:0] kind, logic [63:0] raw_key, logic [3:0] klen_in,
                                 logic [63:0] v, logic [3:0] vlen_in, logic hv);
    int unsigned kl, vl, bkt, link, prev, n;
    logic [63:0] k, h;
    map_result_t r;
    kl = (klen_in > 4'd8) ? 8 : 32'(klen_in);
    vl = (vlen_in > 4'd8) ? 8 : 32'(vlen_in);
    k = raw_key & mask_bytes(kl);
    h = fnv_hash(k, kl);
    bkt = 32'(h[BKT_AW-1:0]);
    r = '0;
    link = head_link[bkt];
    prev = 0;
    while (link != 0) begin
      n = link - 1;
      if (shadow_hash[n] == h && shadow_klen[n] == 4'(kl) && shadow_key[n] == k) break;
      prev = link;
      link = next_link[n];
    end
    if (kind == KIND_ADD || kind == KIND_UPDATE) begin
      if (link != 0) begin
        if (kind == KIND_ADD) r.status = ST_EXISTS;
        else begin
          store_value(link - 1, v, vl, hv);
          r.status = ST_UPDATED;
        end
      end else if (live_count >= NODE_COUNT) begin
        r.status = ST_FULL;
      end else begin
        // Recycled nodes are taken before fresh ones.
        if (free_link != 0) begin
          link = free_link;
          free_link = next_link[link - 1];
        end else begin
          link = taken_count % NODE_COUNT + 1;
          taken_count++;
        end
        n = link - 1;
        next_link[n] = head_link[bkt];
        head_link[bkt] = link;
        shadow_key[n] = k;
        shadow_klen[n] = 4'(kl);
        shadow_hash[n] = h;
        store_value(n, v, vl, hv);
        live_count++;
        r.status = ST_ADDED;
      end
    end else if (link == 0) begin
      r.status = ST_NOT_FOUND;
    end else begin
      n = link - 1;
      r.fval = shadow_val[n];
      r.flen = shadow_vlen[n];
      r.fhv  = shadow_hv[n];
      if (kind == KIND_LOOKUP) r.status = ST_FOUND;
      else begin
        if (prev == 0) head_link[bkt] = next_link[n];
        else next_link[prev - 1] = next_link[n];
        next_link[n] = free_link;
        free_link = link;
        live_count--;
        if (live_count == 0) begin
          free_link = 0;
          taken_count = 0;
        end
        r.status = ST_REMOVED;
      end
    end
    r.total = 9'(live_count);
    result_queue.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
    foreach (head_link[i]) head_link[i] = 0;
    free_link = 0;
    taken_count = 0;
    live_count = 0;
  end

  always @(posedge clk) begin
    map_result_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          report_mismatch("result word with nothing expected", 64'(out_status), 64'd0);
        end else begin
          w = result_queue.pop_front();
          if (out_status !== w.status)
            report_mismatch("status", 64'(out_status), 64'(w.status));
          if (out_found_value !== w.fval)
            report_mismatch("found value", out_found_value, w.fval);
          if (out_found_value_length !== w.flen)
            report_mismatch("found value length", 64'(out_found_value_length), 64'(w.flen));
          if (out_found_has_value !== w.fhv)
            report_mismatch("found has value", 64'(out_found_has_value), 64'(w.fhv));
          if (out_entry_total !== w.total)
            report_mismatch("entry total", 64'(out_entry_total), 64'(w.total));
        end
        result_count++;
      end
      if (in_valid && !in_stall)
        apply_operation(in_kind, in_key, in_key_length, in_value, in_value_length,
                        in_has_value);
      pending_count = result_queue.size();
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Stimulus and verdict for the hash map engine testbench.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import chm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_ADD;
  logic [63:0] in_key = '0;
  logic [3:0]  in_key_length = '0;
  logic [63:0] in_value = '0;
  logic [3:0]  in_value_length = '0;
  logic        in_has_value = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [63:0] out_found_value;
  logic [3:0]  out_found_value_length;
  logic        out_found_has_value;
  logic [8:0]  out_entry_total;

  int fail_count, pending_count, result_count;
  int cycle_count = 0;
  // Percent chances of the sender idling and of the receiver stalling this phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Keys come from a small pool so that later operations hit earlier entries.
  logic [63:0] key_pool[16];
  logic [3:0]  klen_pool[16];

  always #4 clk = ~clk;

  chained_hash_map_engine_core dut (.*);

  chm_result_check u_checker (.*);

  // The receiver stalls at random; the stall is changed only on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Timeout covers the clearing pass and every word at its slowest
  // (long chains when the map is full) under heavy stalling, several times over.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 900000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Presents one word and holds it until the block takes it. A random idle
  // gap with valid low may come before the word. Valid is left high on return;
  // the next word or the drain wait takes it over at the same falling edge.
  task automatic send_word(logic [1:0] kind, logic [63:0] key, logic [3:0] klen,
                           logic [63:0] value, logic [3:0] vlen, logic hv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_key <= key;
    in_key_length <= klen;
    in_value <= value;
    in_value_length <= vlen;
    in_has_value <= hv;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Random word: mostly operations on pooled keys, sometimes fully random fields.
  task automatic send_random_word();
    int p;
    logic [1:0] kind;
    p = $urandom_range(15);
    kind = 2'($urandom_range(3));
    if ($urandom_range(9) == 0)
      send_word(kind, {$urandom, $urandom}, 4'($urandom), {$urandom, $urandom},
                4'($urandom), 1'($urandom));
    else
      send_word(kind, key_pool[p], klen_pool[p], {$urandom, $urandom},
                4'($urandom_range(9)), 1'($urandom));
  endtask

  initial begin
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom};
      klen_pool[i] = 4'($urandom_range(8));
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words: every operation, empty and long keys, over-length fields,
    // set entries, duplicate add, update both ways, remove to empty.
    send_word(KIND_LOOKUP, 64'h0, 4'd0, 64'h0, 4'd0, 1'b0);
    send_word(KIND_ADD, '1, 4'd0, '1, 4'd8, 1'b1);
    send_word(KIND_ADD, 64'hFF, 4'd0, 64'h1, 4'd1, 1'b1);
    send_word(KIND_LOOKUP, 64'h0, 4'd0, 64'h0, 4'd0, 1'b0);
    send_word(KIND_ADD, '1, 4'd15, '1, 4'd15, 1'b1);
    send_word(KIND_LOOKUP, '1, 4'd8, 64'h0, 4'd0, 1'b0);
    send_word(KIND_ADD, 64'h1234_5678_9ABC_DEF0, 4'd3, '1, 4'd5, 1'b0);
    send_word(KIND_LOOKUP, 64'hAA00_0000_00BC_DEF0, 4'd3, 64'h0, 4'd0, 1'b0);
    send_word(KIND_UPDATE, 64'h00BC_DEF0, 4'd3, 64'hA5A5_A5A5_A5A5_A5A5, 4'd2, 1'b1);
    send_word(KIND_UPDATE, 64'h5555_5555_5555_5555, 4'd8, 64'h0, 4'd0, 1'b1);
    send_word(KIND_LOOKUP, 64'h5555_5555_5555_5555, 4'd8, 64'h0, 4'd0, 1'b0);
    send_word(KIND_REMOVE, 64'h00BC_DEF0, 4'd3, 64'h0, 4'd0, 1'b0);
    send_word(KIND_REMOVE, 64'h00BC_DEF0, 4'd3, 64'h0, 4'd0, 1'b0);
    send_word(KIND_REMOVE, '1, 4'd9, 64'h0, 4'd0, 1'b0);
    send_word(KIND_REMOVE, 64'h0, 4'd0, 64'h0, 4'd0, 1'b0);
    send_word(KIND_REMOVE, 64'h5555_5555_5555_5555, 4'd8, 64'h0, 4'd0, 1'b0);
    send_word(KIND_ADD, 64'h7, 4'd1, 64'h9, 4'd1, 1'b1);
    // Pause until every result is in before the random phases.
    wait_drained();

    // Random phases with each idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 26 : 55) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 26 : 55) : 0;
      repeat (30) send_random_word();
    end
    send_idle_pct = 0;
    recv_stall_pct = 10;

    // Fill the map to capacity with unique keys, push past full, then remove
    // them again so the free stack and node recycling are exercised.
    for (int i = 0; i < NODE_COUNT + 4; i++)
      send_word(KIND_UPDATE, {32'hC0DE_0000, 32'(i)}, 4'd8, {$urandom, $urandom},
                4'($urandom_range(8)), 1'($urandom));
    for (int i = 0; i < 10; i++) send_random_word();
    for (int i = 0; i < NODE_COUNT + 4; i++)
      send_word(KIND_REMOVE, {32'hC0DE_0000, 32'(i)}, 4'd8, '0, '0, 1'b0);
    for (int i = 0; i < 16; i++) send_word(KIND_REMOVE, key_pool[i], klen_pool[i], '0, '0, 1'b0);
    repeat (15) send_random_word();

    wait_drained();
    recv_stall_pct = 0;
    repeat (600) @(negedge clk);
    $display("Ran directed words, four idling phases of random words, and a fill");
    $display("past capacity followed by a drain; %0d results checked.",
             result_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/chm_pkg.sv
rtl/chm_ctrl.sv
rtl/chm_dp.sv
rtl/chained_hash_map_engine_core.sv
rtl/chm_checker.sv
dv/chm_checker.sv
dv/testbench.sv
